// File: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned STORE_MAX = 8;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_PAIR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_PAIR   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_INT    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FLOAT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ACK    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_CLEAR  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_STATUS = 4'd7;

    // register reset values
    localparam logic [15:0] RST_HEADER_PAIR = 16'hAA55;
    localparam logic [15:0] RST_TAIL_PAIR   = 16'h0D0A;
    localparam logic [7:0]  RST_CODE_INT    = 8'd1;
    localparam logic [7:0]  RST_CODE_FLOAT  = 8'd2;
    localparam logic [7:0]  RST_CODE_ACK    = 8'd3;
    localparam logic [7:0]  RST_CODE_COUNT  = 8'd4;
    localparam logic [7:0]  RST_CODE_CLEAR  = 8'd5;
    localparam logic [7:0]  RST_CODE_STATUS = 8'd6;

    // payload length that goes with each frame kind
    localparam logic [LEN_W-1:0] LEN_INT    = 4'd4;
    localparam logic [LEN_W-1:0] LEN_FLOAT  = 4'd4;
    localparam logic [LEN_W-1:0] LEN_ACK    = 4'd0;
    localparam logic [LEN_W-1:0] LEN_COUNT  = 4'd2;
    localparam logic [LEN_W-1:0] LEN_CLEAR  = 4'd1;
    localparam logic [LEN_W-1:0] LEN_STATUS = 4'd1;

    typedef enum logic [3:0] {
        PH_HEAD1 = 4'd0,
        PH_HEAD2 = 4'd1,
        PH_TYPE  = 4'd2,
        PH_LEN   = 4'd3,
        PH_DATA  = 4'd4,
        PH_SUMH  = 4'd5,
        PH_SUML  = 4'd6,
        PH_TAIL1 = 4'd7,
        PH_TAIL2 = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        OUT_ACCEPTED = 2'd0,
        OUT_BAD_SUM  = 2'd1,
        OUT_UNKNOWN  = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        KIND_INT    = 3'd0,
        KIND_FLOAT  = 3'd1,
        KIND_ACK    = 3'd2,
        KIND_COUNT  = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_STATUS = 3'd5
    } kind_t;

    typedef struct packed {
        logic [15:0] header_pair;
        logic [15:0] tail_pair;
        logic [7:0]  code_int;
        logic [7:0]  code_float;
        logic [7:0]  code_ack;
        logic [7:0]  code_count;
        logic [7:0]  code_clear;
        logic [7:0]  code_status;
    } cfg_t;

    // finished frame as held by the parser
    typedef struct packed {
        logic [BYTE_W-1:0]    type_byte;
        logic [LEN_W-1:0]     payload_len;
        logic [PAYLOAD_W-1:0] payload;
        logic [SUM_W-1:0]     running_sum;
        logic [SUM_W-1:0]     received_sum;
    } frame_t;

    typedef struct packed {
        outcome_t             outcome;
        kind_t                frame_kind;
        logic [BYTE_W-1:0]    type_byte;
        logic [LEN_W-1:0]     payload_len;
        logic [PAYLOAD_W-1:0] payload;
        logic                 ack_request;
    } result_t;

endpackage

// File: sv/sfr_byte_if.sv
// ----------------------------------------------------------------------------
// sfr_byte_if
// Byte channel into the receiver.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/sfr_result_if.sv
// ----------------------------------------------------------------------------
// sfr_result_if
// Result channel out of the receiver, one transfer per finished frame.
// ----------------------------------------------------------------------------
interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [2:0]  frame_kind;
    logic [7:0]  type_byte;
    logic [3:0]  payload_len;
    logic [63:0] payload;
    logic        ack_request;

    modport source (output valid, output outcome, output frame_kind, output type_byte,
                    output payload_len, output payload, output ack_request, input ready);
    modport sink   (input valid, input outcome, input frame_kind, input type_byte,
                    input payload_len, input payload, input ack_request, output ready);
endinterface

// File: sv/sfr_cfg_if.sv
// ----------------------------------------------------------------------------
// sfr_cfg_if
// Register write channel of the receiver.
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/sfr_cfg.sv
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration registers: header and tail pairs and the six type codes.
// ----------------------------------------------------------------------------
module sfr_cfg
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_HEADER_PAIR: cfg_next.header_pair = wr_data;
                REG_TAIL_PAIR:   cfg_next.tail_pair   = wr_data;
                REG_CODE_INT:    cfg_next.code_int    = wr_data[7:0];
                REG_CODE_FLOAT:  cfg_next.code_float  = wr_data[7:0];
                REG_CODE_ACK:    cfg_next.code_ack    = wr_data[7:0];
                REG_CODE_COUNT:  cfg_next.code_count  = wr_data[7:0];
                REG_CODE_CLEAR:  cfg_next.code_clear  = wr_data[7:0];
                REG_CODE_STATUS: cfg_next.code_status = wr_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_pair <= RST_HEADER_PAIR;
            cfg_reg.tail_pair   <= RST_TAIL_PAIR;
            cfg_reg.code_int    <= RST_CODE_INT;
            cfg_reg.code_float  <= RST_CODE_FLOAT;
            cfg_reg.code_ack    <= RST_CODE_ACK;
            cfg_reg.code_count  <= RST_CODE_COUNT;
            cfg_reg.code_clear  <= RST_CODE_CLEAR;
            cfg_reg.code_status <= RST_CODE_STATUS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/sfr_parse.sv
// ----------------------------------------------------------------------------
// sfr_parse
// Frame phase tracking, payload store and running checksum.
// ----------------------------------------------------------------------------
module sfr_parse
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              frame_done,
    output frame_t            frame
);

    localparam logic [BYTE_W-1:0] LIMIT = BYTE_W'(MAX_PAYLOAD);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [BYTE_W-1:0]   type_reg;
    logic [BYTE_W-1:0]   type_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [LEN_W-1:0]    idx_reg;
    logic [LEN_W-1:0]    idx_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    rsum_reg;
    logic [SUM_W-1:0]    rsum_next;
    logic [BYTE_W-1:0]   store_reg [MAX_PAYLOAD];
    logic [LEN_W-1:0]    clamped_len;
    logic [LEN_W-1:0]    idx_inc;
    logic                store_we;

    assign clamped_len = (rx_byte > LIMIT) ? LIMIT[LEN_W-1:0] : rx_byte[LEN_W-1:0];
    assign idx_inc     = idx_reg + LEN_W'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_en)
        begin
            case (phase_reg)
                PH_HEAD2: phase_next = (rx_byte == cfg.header_pair[7:0]) ? PH_TYPE : PH_HEAD1;
                PH_TYPE:  phase_next = PH_LEN;
                PH_LEN:   phase_next = (clamped_len != '0) ? PH_DATA : PH_SUMH;
                PH_DATA:  phase_next = (idx_inc >= len_reg) ? PH_SUMH : PH_DATA;
                PH_SUMH:  phase_next = PH_SUML;
                PH_SUML:  phase_next = PH_TAIL1;
                PH_TAIL1: phase_next = (rx_byte == cfg.tail_pair[15:8]) ? PH_TAIL2 : PH_HEAD1;
                PH_TAIL2: phase_next = PH_HEAD1;
                default:  phase_next = (rx_byte == cfg.header_pair[15:8]) ? PH_HEAD2 : PH_HEAD1;
            endcase
        end
    end

    // datapath updates per phase
    always_comb
    begin
        type_next  = type_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        rsum_next  = rsum_reg;
        store_we   = 1'b0;
        frame_done = 1'b0;
        if (byte_en)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    sum_next  = {8'h00, rx_byte};
                end
                PH_LEN:
                begin
                    len_next = clamped_len;
                    idx_next = '0;
                    sum_next = sum_reg + {12'h000, clamped_len};
                end
                PH_DATA:
                begin
                    store_we = 1'b1;
                    sum_next = sum_reg + {8'h00, rx_byte};
                    idx_next = idx_inc;
                end
                PH_SUMH:  rsum_next  = {rx_byte, rsum_reg[7:0]};
                PH_SUML:  rsum_next  = {rsum_reg[15:8], rx_byte};
                PH_TAIL2: frame_done = (rx_byte == cfg.tail_pair[7:0]);
                default:  frame_done = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD1;
            type_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            rsum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            rsum_reg  <= rsum_next;
        end
    end

    // each store byte is written at its own slot, bytes past the length read as zero
    for (genvar i = 0; i < STORE_MAX; i++)
    begin : g_slot
        if (i < MAX_PAYLOAD)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (store_we && idx_reg == LEN_W'(i))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
            assign frame.payload[8*i +: 8] = (LEN_W'(i) < len_reg) ? store_reg[i] : 8'h00;
        end
        else
        begin : g_unused
            assign frame.payload[8*i +: 8] = 8'h00;
        end
    end

    assign frame.type_byte    = type_reg;
    assign frame.payload_len  = len_reg;
    assign frame.running_sum  = sum_reg;
    assign frame.received_sum = rsum_reg;

endmodule

// File: sv/sfr_check.sv
// ----------------------------------------------------------------------------
// sfr_check
// Checksum compare and frame classification of a finished frame.
// ----------------------------------------------------------------------------
module sfr_check
    import sfr_pkg::*;
(
    input  cfg_t    cfg,
    input  frame_t  frame,
    output result_t result
);

    logic     hit_int;
    logic     hit_float;
    logic     hit_ack;
    logic     hit_count;
    logic     hit_clear;
    logic     hit_status;
    outcome_t outcome;
    kind_t    kind;

    assign hit_int    = frame.type_byte == cfg.code_int    && frame.payload_len == LEN_INT;
    assign hit_float  = frame.type_byte == cfg.code_float  && frame.payload_len == LEN_FLOAT;
    assign hit_ack    = frame.type_byte == cfg.code_ack    && frame.payload_len == LEN_ACK;
    assign hit_count  = frame.type_byte == cfg.code_count  && frame.payload_len == LEN_COUNT;
    assign hit_clear  = frame.type_byte == cfg.code_clear  && frame.payload_len == LEN_CLEAR;
    assign hit_status = frame.type_byte == cfg.code_status && frame.payload_len == LEN_STATUS;

    // first match in list order wins when codes collide
    always_comb
    begin
        outcome = OUT_ACCEPTED;
        kind    = KIND_INT;
        if (frame.running_sum != frame.received_sum)
        begin
            outcome = OUT_BAD_SUM;
        end
        else if (hit_int)
        begin
            kind = KIND_INT;
        end
        else if (hit_float)
        begin
            kind = KIND_FLOAT;
        end
        else if (hit_ack)
        begin
            kind = KIND_ACK;
        end
        else if (hit_count)
        begin
            kind = KIND_COUNT;
        end
        else if (hit_clear)
        begin
            kind = KIND_CLEAR;
        end
        else if (hit_status)
        begin
            kind = KIND_STATUS;
        end
        else
        begin
            outcome = OUT_UNKNOWN;
        end
    end

    assign result.outcome     = outcome;
    assign result.frame_kind  = kind;
    assign result.type_byte   = frame.type_byte;
    assign result.payload_len = frame.payload_len;
    assign result.payload     = frame.payload;
    assign result.ack_request = (outcome == OUT_ACCEPTED) && (kind != KIND_ACK);

endmodule

// File: sv/sfr_outbuf.sv
// ----------------------------------------------------------------------------
// sfr_outbuf
// Result output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module sfr_outbuf
    import sfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_take = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            // output slot free: refill from skid first, else from the new result
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Byte-serial frame parser with header/tail match and additive checksum.
//
//   channel | dir | payload                                         | transfer
//   --------+-----+-------------------------------------------------+-----------------
//   rx      | in  | rx_byte                                         | valid && ready
//   res     | out | outcome, frame_kind, type_byte, payload_len,    | valid && ready
//           |     | payload, ack_request                            |
//   cfg     | in  | index, data                                     | valid && ready
//
// One byte per cycle while the skid entry is free: the phase update and the
// 16-bit checksum add sit between the parse state registers, and the result
// of the closing tail byte is registered into the output or skid register.
// Reset returns the parser to hunting for header byte one and loads the
// register defaults; cfg is always ready.
// rx stalls only when both the output register and its skid entry are full.
// ----------------------------------------------------------------------------
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    sfr_byte_if.sink     rx,
    sfr_result_if.source res,
    sfr_cfg_if.sink      cfg
);

    cfg_t    cfg_regs;
    frame_t  frame;
    result_t result;
    result_t out_data;
    logic    frame_done;
    logic    byte_en;
    logic    can_take;

    assign cfg.ready = 1'b1;
    assign rx.ready  = can_take;
    assign byte_en   = rx.valid && can_take;

    sfr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    sfr_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .rx_byte    (rx.rx_byte),
        .cfg        (cfg_regs),
        .frame_done (frame_done),
        .frame      (frame)
    );

    sfr_check u_check (
        .cfg    (cfg_regs),
        .frame  (frame),
        .result (result)
    );

    sfr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_done),
        .push_data (result),
        .can_take  (can_take),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (out_data)
    );

    assign res.outcome     = out_data.outcome;
    assign res.frame_kind  = out_data.frame_kind;
    assign res.type_byte   = out_data.type_byte;
    assign res.payload_len = out_data.payload_len;
    assign res.payload     = out_data.payload;
    assign res.ack_request = out_data.ack_request;

endmodule
